FILE: hdl/gtl_pkg.sv
// Shared types, constants and register codes of the glyph layout engine.
package gtl_pkg;

  localparam int unsigned SCREEN_W        = 131;
  localparam int unsigned SCREEN_H        = 80;
  localparam int unsigned NUM_CHUNKS_DEF  = 4;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned CHUNK_IDX_W = 2;
  localparam int unsigned BASE_W      = 24;
  localparam int unsigned START_W     = 14;
  localparam int unsigned CODE_W      = 15;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam logic [7:0] LEAD_MIN  = 8'hA0;
  localparam logic [7:0] NEWLINE   = 8'h0A;
  localparam int         ROWS_PER  = 94;
  localparam int         SPACE     = 32;
  localparam int         LOW_ROW   = 3;
  // linear code of a single low byte is byte + LOW_CODE_OFS
  localparam int         LOW_CODE_OFS = (LOW_ROW - 1) * ROWS_PER - SPACE - 1;
  localparam int         LEAD_OFS     = 161;

  typedef enum logic [1:0] {
    ACT_TEXT    = 2'd0,
    ACT_CHUNK   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_GLYPH = 2'd0,
    KIND_BREAK = 2'd1,
    KIND_PAGE  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OP_CHUNK,
    OP_RESTART,
    OP_LEAD,
    OP_NEWLINE,
    OP_GLYPH
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_START_X  = 3'd0,
    REG_PAGE_START_Y  = 3'd1,
    REG_GLYPH_ROWS    = 3'd2,
    REG_GLYPH_ADVANCE = 3'd3,
    REG_LINE_GAP      = 3'd4,
    REG_GLYPH_BYTES   = 3'd5
  } reg_e;

  typedef struct packed {
    op_e                         op;
    logic signed [CODE_W-1:0]    code;
    logic [CHUNK_IDX_W-1:0]      chunk_idx;
    logic [BASE_W-1:0]           base;
    logic [START_W-1:0]          start;
  } op_t;

  typedef struct packed {
    logic [7:0] line_start_x;
    logic [7:0] page_start_y;
    logic [6:0] glyph_rows;
    logic [6:0] glyph_advance;
    logic [6:0] line_gap;
    logic [9:0] glyph_bytes;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        pos_x;
    logic [7:0]        pos_y;
    logic [BASE_W-1:0] glyph_addr;
    logic              page_full;
    logic              bad_code;
    logic              last;
  } res_t;

endpackage

FILE: hdl/gtl_front.sv
// Front end: decodes actions, pairs lead bytes and forms linear codes.
module gtl_front import gtl_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             action_i,
  input  logic [7:0]             text_byte_i,
  input  logic [CHUNK_IDX_W-1:0] chunk_idx_i,
  input  logic [BASE_W-1:0]      chunk_base_i,
  input  logic [START_W-1:0]     chunk_start_i,
  output logic                   push_o,
  output op_t                    op_o,
  input  logic                   q_full_i
);

  logic              lead_pending_q, lead_pending_d;
  logic [7:0]        lead_value_q;
  logic              fire;
  logic signed [8:0] row_s, cell_s;
  logic signed [15:0] lead_code;
  logic [CODE_W-1:0]  low_code;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  assign row_s     = $signed({1'b0, lead_value_q}) - 9'sd161;
  assign cell_s    = $signed({1'b0, text_byte_i}) - 9'sd161;
  assign lead_code = 16'(row_s) * 16'(ROWS_PER) + 16'(cell_s);
  assign low_code  = CODE_W'(text_byte_i) + CODE_W'(LOW_CODE_OFS);

  always_comb begin
    lead_pending_d  = lead_pending_q;
    push_o          = 1'b0;
    op_o.op         = OP_CHUNK;
    op_o.code       = '0;
    op_o.chunk_idx  = chunk_idx_i;
    op_o.base       = chunk_base_i;
    op_o.start      = chunk_start_i;
    unique case (action_e'(action_i))
      ACT_CHUNK: begin
        push_o  = fire;
        op_o.op = OP_CHUNK;
      end
      ACT_RESTART: begin
        push_o         = fire;
        op_o.op        = OP_RESTART;
        lead_pending_d = 1'b0;
      end
      ACT_TEXT: begin
        push_o = fire;
        if (!lead_pending_q && text_byte_i >= LEAD_MIN) begin
          op_o.op        = OP_LEAD;
          lead_pending_d = 1'b1;
        end else if (!lead_pending_q && text_byte_i == NEWLINE) begin
          op_o.op = OP_NEWLINE;
        end else begin
          op_o.op        = OP_GLYPH;
          op_o.code      = lead_pending_q ? lead_code[CODE_W-1:0] : low_code;
          lead_pending_d = 1'b0;
        end
      end
      ACT_NOP: begin
        push_o = 1'b0;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
    end else if (fire) begin
      lead_pending_q <= lead_pending_d;
    end
  end

  // lead byte is only read while pending
  always_ff @(posedge clk_i) begin
    if (fire && !lead_pending_q && action_e'(action_i) == ACT_TEXT &&
        text_byte_i >= LEAD_MIN) begin
      lead_value_q <= text_byte_i;
    end
  end

endmodule

FILE: hdl/gtl_queue.sv
// Short op queue between front and back end.
module gtl_queue import gtl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  output logic valid_o,
  output op_t  op_o,
  input  logic pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= op_i;
  end

endmodule

FILE: hdl/gtl_back.sv
// Back end: cursor and page tracking, chunk lookup, address stage, output register.
module gtl_back import gtl_pkg::*; #(
  parameter int unsigned NUM_CHUNKS = NUM_CHUNKS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_valid_i,
  input  op_t  op_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic [BASE_W-1:0]  chunk_base_q  [NUM_CHUNKS];
  logic [START_W-1:0] chunk_start_q [NUM_CHUNKS];

  logic [7:0] cursor_x_q, cursor_x_d;
  logic [7:0] cursor_y_q, cursor_y_d;
  logic       page_done_q, page_done_d;
  logic       page_fresh_q, page_fresh_d;

  logic               s2_valid_q;
  res_t               s2_res_q;
  logic [BASE_W-1:0]  s2_base_q;
  logic [START_W-1:0] s2_off_q;
  res_t               s2_out;

  logic out_valid_q;
  res_t out_res_q;

  logic out_adv, s2_free, fire;
  logic emit, chunk_we;
  res_t emit_res;
  logic [BASE_W-1:0]  emit_base;
  logic [START_W-1:0] emit_off;

  // cursor step
  logic [7:0] ax;
  logic [8:0] ay;
  logic       x_fits, y_fits;
  logic [7:0] line_y;

  // chunk search
  logic               hit;
  logic [BASE_W-1:0]  sel_base;
  logic [START_W-1:0] sel_start;

  logic [BASE_W-1:0] prod;

  assign out_adv = !out_valid_q || out_ready_i;
  assign s2_free = !s2_valid_q || out_adv;
  assign fire    = q_valid_i && s2_free;

  assign ax = (op_i.op == OP_NEWLINE) ? 8'(SCREEN_W) : cursor_x_q;
  assign ay = (op_i.op == OP_NEWLINE) ? {1'b0, cursor_y_q} + {2'b0, cfg_i.glyph_rows}
                                      : {1'b0, cursor_y_q};
  assign x_fits = ({2'b0, ax} + {2'b0, cfg_i.glyph_advance, 1'b0}) <= 10'(SCREEN_W);
  assign y_fits = ({1'b0, ay} + {2'b0, cfg_i.glyph_rows, 1'b0} + {3'b0, cfg_i.line_gap})
                  <= 10'(SCREEN_H);
  assign line_y = 8'({1'b0, ay} + {3'b0, cfg_i.glyph_rows} + {3'b0, cfg_i.line_gap});

  // first entry from index 0 upward whose start the code reaches
  always_comb begin
    hit       = 1'b0;
    sel_base  = '0;
    sel_start = '0;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (!op_i.code[CODE_W-1] && op_i.code[START_W-1:0] >= chunk_start_q[i]) begin
        hit       = 1'b1;
        sel_base  = chunk_base_q[i];
        sel_start = chunk_start_q[i];
      end
    end
  end

  always_comb begin
    cursor_x_d          = cursor_x_q;
    cursor_y_d          = cursor_y_q;
    page_done_d         = page_done_q;
    page_fresh_d        = page_fresh_q;
    pop_o               = 1'b0;
    emit                = 1'b0;
    chunk_we            = 1'b0;
    emit_res.kind       = KIND_GLYPH;
    emit_res.pos_x      = cursor_x_q;
    emit_res.pos_y      = cursor_y_q;
    emit_res.glyph_addr = '0;
    emit_res.page_full  = 1'b0;
    emit_res.bad_code   = 1'b0;
    emit_res.last       = 1'b1;
    emit_base           = '0;
    emit_off            = '0;
    if (fire) begin
      if (op_i.op == OP_CHUNK) begin
        pop_o    = 1'b1;
        chunk_we = 1'b1;
      end else if (op_i.op == OP_RESTART ||
                   (page_done_q && (op_i.op == OP_LEAD || op_i.op == OP_NEWLINE ||
                                    op_i.op == OP_GLYPH))) begin
        // new page; a glyph stays queued and is drawn when it is next taken
        cursor_x_d     = cfg_i.line_start_x;
        cursor_y_d     = cfg_i.page_start_y;
        page_done_d    = 1'b0;
        page_fresh_d   = (op_i.op == OP_RESTART);
        emit           = 1'b1;
        emit_res.kind  = KIND_PAGE;
        emit_res.pos_x = cfg_i.line_start_x;
        emit_res.pos_y = cfg_i.page_start_y;
        emit_res.last  = (op_i.op != OP_GLYPH);
        pop_o          = (op_i.op != OP_GLYPH);
        if (op_i.op == OP_GLYPH) page_fresh_d = 1'b1;
      end else if (op_i.op == OP_LEAD) begin
        pop_o        = 1'b1;
        page_fresh_d = 1'b0;
      end else if (op_i.op == OP_NEWLINE || op_i.op == OP_GLYPH) begin
        pop_o        = 1'b1;
        page_fresh_d = 1'b0;
        // newline at the top of a page is swallowed
        if (op_i.op == OP_GLYPH || !page_fresh_q) begin
          emit          = 1'b1;
          emit_res.kind = (op_i.op == OP_GLYPH) ? KIND_GLYPH : KIND_BREAK;
          if (x_fits) begin
            cursor_x_d = 8'({2'b0, ax} + {3'b0, cfg_i.glyph_advance});
            cursor_y_d = ay[7:0];
          end else if (y_fits) begin
            cursor_x_d = cfg_i.line_start_x;
            cursor_y_d = line_y;
          end else begin
            page_done_d        = 1'b1;
            emit_res.page_full = 1'b1;
          end
          if (op_i.op == OP_GLYPH) begin
            emit_res.bad_code = !hit;
            if (hit) begin
              emit_base = sel_base;
              emit_off  = op_i.code[START_W-1:0] - sel_start;
            end
          end
        end
      end else begin
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      page_done_q  <= 1'b0;
      page_fresh_q <= 1'b1;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      page_done_q  <= page_done_d;
      page_fresh_q <= page_fresh_d;
      if (s2_free) s2_valid_q  <= emit;
      if (out_adv) out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_CHUNKS; i++) begin
      if (chunk_we && int'(op_i.chunk_idx) == i) begin
        chunk_base_q[i]  <= op_i.base;
        chunk_start_q[i] <= op_i.start;
      end
    end
  end

  assign prod = {{(BASE_W-START_W){1'b0}}, s2_off_q} *
                {{(BASE_W-10){1'b0}}, cfg_i.glyph_bytes};

  always_comb begin
    s2_out            = s2_res_q;
    s2_out.glyph_addr = s2_base_q + prod;
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && emit) begin
      s2_res_q  <= emit_res;
      s2_base_q <= emit_base;
      s2_off_q  <= emit_off;
    end
    if (out_adv && s2_valid_q) begin
      out_res_q <= s2_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_res_q;

endmodule

FILE: hdl/text_glyph_layout_engine.sv
// Top level of the GB2312 glyph layout engine.
//
//  port group   dir  transfer contents
//  s_axis_*     in   one text byte, chunk table write or page restart
//  m_axis_*     out  one glyph, line break or new page result
//  cfg_*        in   register write, index 0..5, no read-back
//
// The front end takes one input byte per clock while its two-entry queue has room.
// The back end retires one queued op per clock while its address stage has room; a
// glyph arriving on a full page stays queued for the new-page result, then is drawn.
// After its op is taken, a result passes lookup, address multiply and the output
// register. The chunk table has no reset; load all entries before text.
// A stalled m_axis side fills the output register, the address stage, then the
// queue, after which s_axis_tready drops.
module text_glyph_layout_engine import gtl_pkg::*; #(
  parameter int unsigned NUM_CHUNKS = NUM_CHUNKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // text_byte[7:0], chunk_index[9:8], chunk_base[33:10], chunk_start[47:34]
  input  logic [47:0]           s_axis_tdata,
  // action[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pos_x[7:0], pos_y[15:8], glyph_addr[39:16], page_full[40], bad_code[41], zero[47:42]
  output logic [47:0]           m_axis_tdata,
  // kind[1:0]
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic push, q_full, q_valid, pop;
  op_t  push_op, head_op;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_start_x  <= 8'd0;
      cfg_q.page_start_y  <= 8'd0;
      cfg_q.glyph_rows    <= 7'd12;
      cfg_q.glyph_advance <= 7'd12;
      cfg_q.line_gap      <= 7'd1;
      cfg_q.glyph_bytes   <= 10'd24;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINE_START_X:  cfg_q.line_start_x  <= cfg_wdata_i[7:0];
        REG_PAGE_START_Y:  cfg_q.page_start_y  <= cfg_wdata_i[7:0];
        REG_GLYPH_ROWS:    cfg_q.glyph_rows    <= cfg_wdata_i[6:0];
        REG_GLYPH_ADVANCE: cfg_q.glyph_advance <= cfg_wdata_i[6:0];
        REG_LINE_GAP:      cfg_q.line_gap      <= cfg_wdata_i[6:0];
        REG_GLYPH_BYTES:   cfg_q.glyph_bytes   <= cfg_wdata_i[9:0];
        default: begin
        end
      endcase
    end
  end

  gtl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .action_i      (s_axis_tuser),
    .text_byte_i   (s_axis_tdata[7:0]),
    .chunk_idx_i   (s_axis_tdata[9:8]),
    .chunk_base_i  (s_axis_tdata[33:10]),
    .chunk_start_i (s_axis_tdata[47:34]),
    .push_o        (push),
    .op_o          (push_op),
    .q_full_i      (q_full)
  );

  gtl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (head_op),
    .pop_i   (pop)
  );

  gtl_back #(
    .NUM_CHUNKS (NUM_CHUNKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .op_i        (head_op),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {6'b0, res.bad_code, res.page_full, res.glyph_addr,
                         res.pos_y, res.pos_x};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  a_page_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_PAGE |->
      m_axis_tdata[41:40] == 2'b00 && m_axis_tdata[39:16] == 24'd0)
    else $error("new-page result carries flags or an address");

  a_bad_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[41] |->
      m_axis_tuser == KIND_GLYPH && m_axis_tdata[39:16] == 24'd0)
    else $error("bad code result with an address or wrong kind");

  a_break_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_BREAK |->
      m_axis_tdata[39:16] == 24'd0 && !m_axis_tdata[41])
    else $error("line break result with an address");

  a_only_page_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == KIND_PAGE)
    else $error("non-final result that is not a new page");

endmodule
